// ===== src/psm_pkg.sv =====
`default_nettype none
package psm_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [TimeW-1:0] TimeoutReset = TimeW'(60000);

    // register indexes on the config port
    localparam logic [CfgIdxW-1:0] CFG_TURN_ON_TIMEOUT  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_TURN_OFF_TIMEOUT = CfgIdxW'(1);

    // status codes as seen on the output
    localparam logic [StatusW-1:0] STATUS_START    = 3'd0;
    localparam logic [StatusW-1:0] STATUS_ON       = 3'd1;
    localparam logic [StatusW-1:0] STATUS_OFF      = 3'd2;
    localparam logic [StatusW-1:0] STATUS_TURN_ON  = 3'd3;
    localparam logic [StatusW-1:0] STATUS_TURN_OFF = 3'd4;
    localparam logic [StatusW-1:0] STATUS_ON_ERR   = 3'd5;
    localparam logic [StatusW-1:0] STATUS_OFF_ERR  = 3'd6;

    typedef enum logic [6:0] {
        S_START    = 7'b0000001,
        S_ON       = 7'b0000010,
        S_OFF      = 7'b0000100,
        S_TURN_ON  = 7'b0001000,
        S_TURN_OFF = 7'b0010000,
        S_ON_ERR   = 7'b0100000,
        S_OFF_ERR  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [TimeW-1:0] turn_on_timeout_ms;
        logic [TimeW-1:0] turn_off_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             led_lit;
        logic             need_on;
    } t_poll;

    function automatic logic [StatusW-1:0] state_code(input t_state s);
        logic [StatusW-1:0] code;
        unique case (s)
            S_ON:       code = STATUS_ON;
            S_OFF:      code = STATUS_OFF;
            S_TURN_ON:  code = STATUS_TURN_ON;
            S_TURN_OFF: code = STATUS_TURN_OFF;
            S_ON_ERR:   code = STATUS_ON_ERR;
            S_OFF_ERR:  code = STATUS_OFF_ERR;
            default:    code = STATUS_START;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== src/psm_cfg.sv =====
`default_nettype none
module psm_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [psm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [psm_pkg::TimeW-1:0]   i_cfg_data,
    output psm_pkg::t_cfg                    o_cfg
);
    import psm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_on_timeout_ms  <= TimeoutReset;
            r_cfg.turn_off_timeout_ms <= TimeoutReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TURN_ON_TIMEOUT:  r_cfg.turn_on_timeout_ms  <= i_cfg_data;
                CFG_TURN_OFF_TIMEOUT: r_cfg.turn_off_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== src/psm_fsm.sv =====
`default_nettype none
module psm_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  psm_pkg::t_poll                   i_poll,
    input  psm_pkg::t_cfg                    i_cfg,
    output logic [psm_pkg::StatusW-1:0]      o_status
);
    import psm_pkg::*;

    t_state           r_state, n_state;
    logic [TimeW-1:0] r_start, n_start;
    logic [TimeW-1:0] elapsed;

    // wrap-safe elapsed time since the phase began
    assign elapsed = i_poll.now_ms - r_start;

    always_comb begin
        n_state = r_state;
        n_start = r_start;
        unique case (r_state)
            S_TURN_ON: begin
                if (i_poll.led_lit) begin
                    n_state = S_ON;
                end else if (elapsed >= i_cfg.turn_on_timeout_ms) begin
                    n_state = S_ON_ERR;
                end
            end
            S_TURN_OFF: begin
                if (!i_poll.led_lit) begin
                    n_state = S_OFF;
                end else if (elapsed >= i_cfg.turn_off_timeout_ms) begin
                    n_state = S_OFF_ERR;
                end
            end
            S_ON_ERR, S_OFF_ERR: begin
                if (i_poll.led_lit && i_poll.need_on) begin
                    n_state = S_ON;
                end else if (!i_poll.led_lit && !i_poll.need_on) begin
                    n_state = S_OFF;
                end
            end
            default: begin
                // steady states: start, on, off
                if (i_poll.led_lit == i_poll.need_on) begin
                    n_state = i_poll.led_lit ? S_ON : S_OFF;
                end else begin
                    n_start = i_poll.now_ms;
                    n_state = i_poll.need_on ? S_TURN_ON : S_TURN_OFF;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
            r_start <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    assign o_status = state_code(n_state);

endmodule
`default_nettype wire

// ===== src/power_status_monitor_with_timeout.sv =====
// channel | valid       | stall       | payload
// --------+-------------+-------------+--------------------------------------
// poll in | i_in_valid  | o_in_stall  | i_in_now_ms, i_in_led_lit, i_in_need_on
// status  | o_out_valid | i_out_stall | o_out_status
// config  | i_cfg_we    | (none)      | i_cfg_idx, i_cfg_data
//
// one poll per cycle sustained while the status side is not stalling; a poll's
// status passes from the input register through the state update into the result
// register, and a status stall can hold it in the input register on the way
// reset is synchronous, active low; both registers empty, status start,
// timeouts back to 60000 ms
// a stall on the status side holds the result register; the input register
// still drains into it once it frees, so o_in_stall rises only when both are full
`default_nettype none
module power_status_monitor_with_timeout (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [psm_pkg::TimeW-1:0]   i_in_now_ms,
    input  wire logic                        i_in_led_lit,
    input  wire logic                        i_in_need_on,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [psm_pkg::StatusW-1:0]      o_out_status,
    input  wire logic                        i_cfg_we,
    input  wire logic [psm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [psm_pkg::TimeW-1:0]   i_cfg_data
);
    import psm_pkg::*;

    t_cfg               cfg;
    t_poll              r_poll;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [StatusW-1:0] r_status;
    logic [StatusW-1:0] next_status;
    logic               step;
    logic               in_take;

    // timeout registers
    psm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // the held poll moves into the result register when that is free or draining
    assign step    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = !r_in_valid || step;

    assign o_in_stall = !in_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_poll.now_ms  <= i_in_now_ms;
            r_poll.led_lit <= i_in_led_lit;
            r_poll.need_on <= i_in_need_on;
        end
    end

    // status state and phase timer, updated once per transaction
    psm_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_poll   (r_poll),
        .i_cfg    (cfg),
        .o_status (next_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status <= next_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_status;

endmodule
`default_nettype wire

// ===== src/psm_checker.sv =====
`default_nettype none
module psm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [psm_pkg::StatusW-1:0] o_out_status
);
    import psm_pkg::*;

    // result register empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // status code seven is never produced
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_status != 3'd7))
        else $error("unreachable status code");

    // input stalls only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_status)))
        else $error("stalled result changed");

endmodule

bind power_status_monitor_with_timeout psm_checker u_psm_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import psm_pkg::*;

// tracks the power status the block should report and holds the statuses still owed
class status_tracker;
    typedef struct {
        t_poll              poll;
        logic [StatusW-1:0] status;
    } t_owed;

    logic [TimeW-1:0]   on_limit_ms;
    logic [TimeW-1:0]   off_limit_ms;
    logic [StatusW-1:0] power_state;
    logic [TimeW-1:0]   phase_start_ms;
    t_owed              owed_status[$];
    int unsigned        mismatches;

    function new();
        on_limit_ms    = TimeoutReset;
        off_limit_ms   = TimeoutReset;
        power_state    = STATUS_START;
        phase_start_ms = '0;
        mismatches     = 0;
    endfunction

    function void set_limit(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] value);
        if (idx == CFG_TURN_ON_TIMEOUT) begin
            on_limit_ms = value;
        end else if (idx == CFG_TURN_OFF_TIMEOUT) begin
            off_limit_ms = value;
        end
    endfunction

    // advance the status for one accepted poll transaction
    function void note_poll(t_poll p);
        logic [TimeW-1:0] elapsed;
        t_owed            entry;
        elapsed = p.now_ms - phase_start_ms;
        case (power_state)
            STATUS_TURN_ON: begin
                if (elapsed >= on_limit_ms) power_state = STATUS_ON_ERR;
                if (p.led_lit) power_state = STATUS_ON;
            end
            STATUS_TURN_OFF: begin
                if (elapsed >= off_limit_ms) power_state = STATUS_OFF_ERR;
                if (!p.led_lit) power_state = STATUS_OFF;
            end
            STATUS_ON_ERR, STATUS_OFF_ERR: begin
                if (p.led_lit && p.need_on) power_state = STATUS_ON;
                else if (!p.led_lit && !p.need_on) power_state = STATUS_OFF;
            end
            default: begin
                if (p.led_lit && p.need_on) begin
                    power_state = STATUS_ON;
                end else if (p.led_lit) begin
                    phase_start_ms = p.now_ms;
                    power_state    = STATUS_TURN_OFF;
                end else if (p.need_on) begin
                    phase_start_ms = p.now_ms;
                    power_state    = STATUS_TURN_ON;
                end else begin
                    power_state = STATUS_OFF;
                end
            end
        endcase
        entry.poll   = p;
        entry.status = power_state;
        owed_status.push_back(entry);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_status(logic [StatusW-1:0] got);
        t_owed entry;
        if (owed_status.size() == 0) begin
            report($sformatf("status %0d with no poll outstanding", got));
        end else begin
            entry = owed_status.pop_front();
            if (got !== entry.status) begin
                report($sformatf("now=%h led=%0b want=%0b: status %0d, expected %0d",
                    entry.poll.now_ms, entry.poll.led_lit, entry.poll.need_on,
                    got, entry.status));
            end
        end
    endtask
endclass

module testbench;
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [TimeW-1:0]     i_in_now_ms  = '0;
    logic                 i_in_led_lit = 1'b0;
    logic                 i_in_need_on = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [StatusW-1:0]   o_out_status;
    logic                 i_cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx    = '0;
    logic [TimeW-1:0]     i_cfg_data   = '0;

    status_tracker tracker;

    // percent of cycles in which the poll side holds back / the status side stalls
    int unsigned in_gap_pct    = 0;
    int unsigned out_stall_pct = 0;

    // millisecond time advanced between polls of the random sequences
    logic [TimeW-1:0] clock_ms;

    power_status_monitor_with_timeout dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_now_ms  (i_in_now_ms),
        .i_in_led_lit (i_in_led_lit),
        .i_in_need_on (i_in_need_on),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_status (o_out_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // status side: check each accepted transaction on pre-edge values, then pick the
    // next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_status(o_out_status);
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    function automatic logic coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    // time advance between polls, biased toward the timeout boundary
    function automatic logic [TimeW-1:0] pick_step(logic [TimeW-1:0] limit);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return TimeW'(1);
            2: return limit - 1;
            3: return limit;
            4: return limit >> 1;
            5: return (limit >> 2) + TimeW'($urandom_range(0, 3));
            6: return $urandom();
            default: return TimeW'($urandom_range(0, 3));
        endcase
    endfunction

    // offer one poll transaction, with random hold-off, and wait for it to be taken
    task automatic send_poll(logic [TimeW-1:0] now, logic led, logic want);
        t_poll p;
        p.now_ms  = now;
        p.led_lit = led;
        p.need_on = want;
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_now_ms  <= now;
        i_in_led_lit <= led;
        i_in_need_on <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_poll(p);
    endtask

    // stop offering polls and let every owed status come out
    task automatic settle();
        i_in_valid <= 1'b0;
        for (int n = 0; n < 20000 && tracker.owed_status.size() != 0; n++) begin
            @(posedge i_clk);
        end
        // two-stage pipeline, plus a spare margin
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_limit(idx, value);
    endtask

    // mostly well-formed request/LED sequences, some noise and broken sequences
    task automatic run_random(int unsigned count);
        int unsigned      sent;
        int unsigned      lag;
        int unsigned      hold;
        logic             want;
        logic [TimeW-1:0] limit;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                // noise: any time, any LED, any request
                send_poll($urandom(), coin(), coin());
                sent++;
            end else begin
                // request changes, LED follows after a few polls (or not in time)
                want  = coin();
                limit = want ? tracker.on_limit_ms : tracker.off_limit_ms;
                lag   = $urandom_range(0, 5);
                hold  = $urandom_range(1, 3);
                for (int k = 0; k < lag + hold; k++) begin
                    clock_ms += pick_step(limit);
                    if ($urandom_range(0, 99) < 8) begin
                        // broken sequence: stray LED or request
                        send_poll(clock_ms, coin(), coin());
                    end else begin
                        send_poll(clock_ms, (k < lag) ? !want : want, want);
                    end
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker       = new();
        in_gap_pct    = 19;
        out_stall_pct = 82;
        clock_ms      = $urandom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset timeouts of 60000 ms
        send_poll(32'd100, 1'b1, 1'b1);         // start -> on
        send_poll(32'd200, 1'b1, 1'b0);         // turn off begins at 200
        send_poll(32'd60199, 1'b1, 1'b0);       // one short of the limit
        send_poll(32'd60200, 1'b0, 1'b0);       // expiry and LED dark together: off
        send_poll(32'd60300, 1'b0, 1'b1);       // turn on begins
        send_poll(32'd120300, 1'b0, 1'b1);      // exactly at limit: on error
        send_poll(32'd120301, 1'b0, 1'b1);      // error holds while LED disagrees
        send_poll(32'd120302, 1'b1, 1'b0);      // still disagreeing the other way
        send_poll(32'd120303, 1'b0, 1'b0);      // agreement dark: off
        send_poll(32'hFFFF_FFF0, 1'b0, 1'b1);   // turn on just before wrap
        send_poll(32'h0000_EA4F, 1'b0, 1'b1);   // across wrap, one short
        send_poll(32'h0000_EA50, 1'b0, 1'b1);   // across wrap, at limit
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);   // error -> on
        send_poll(32'h0000_0000, 1'b1, 1'b0);   // turn off begins at zero
        send_poll(32'h0000_EA60, 1'b1, 1'b0);   // off error
        send_poll(32'h0000_EA61, 1'b1, 1'b1);   // error -> on
        run_random(180);
        settle();

        // zero turn-on timeout, largest turn-off timeout
        write_limit(CFG_TURN_ON_TIMEOUT, '0);
        write_limit(CFG_TURN_OFF_TIMEOUT, '1);
        send_poll(32'd5, 1'b0, 1'b1);           // turn on begins
        send_poll(32'd5, 1'b0, 1'b1);           // zero timeout: error at once
        send_poll(32'd6, 1'b1, 1'b1);           // error -> on
        send_poll(32'd7, 1'b0, 1'b1);           // turn on begins
        send_poll(32'd8, 1'b1, 1'b1);           // LED wins over zero timeout
        send_poll(32'd9, 1'b1, 1'b0);           // turn off begins at 9
        send_poll(32'd8, 1'b1, 1'b0);           // difference all ones: off error
        send_poll(32'd10, 1'b0, 1'b0);          // error -> off
        run_random(180);
        settle();

        // swap the idling: sender mostly idle, receiver mostly ready
        in_gap_pct    = 82;
        out_stall_pct = 19;
        write_limit(CFG_TURN_ON_TIMEOUT, '1);
        write_limit(CFG_TURN_OFF_TIMEOUT, '0);
        run_random(180);
        settle();

        write_limit(CFG_TURN_ON_TIMEOUT, TimeW'(1));
        write_limit(CFG_TURN_OFF_TIMEOUT, TimeW'(2));
        run_random(180);
        settle();

        // full rate both ways
        in_gap_pct    = 0;
        out_stall_pct = 0;
        write_limit(CFG_TURN_ON_TIMEOUT, TimeW'($urandom_range(0, 200000)));
        write_limit(CFG_TURN_OFF_TIMEOUT, TimeW'($urandom_range(0, 200000)));
        run_random(180);
        settle();

        write_limit(CFG_TURN_ON_TIMEOUT, $urandom());
        write_limit(CFG_TURN_OFF_TIMEOUT, $urandom());
        run_random(180);
        settle();

        if (tracker.owed_status.size() != 0) begin
            tracker.report($sformatf("%0d statuses never arrived",
                tracker.owed_status.size()));
        end
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
